### rtl/assert_macros.svh
// assertion macros used by the signed decimal formatter
// define NO_ASSERTIONS to compile every check away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

### rtl/sdf_pkg.sv
// constants, types and the bcd shift step of the signed decimal formatter
// no dependencies
package sdf_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int DIGIT_W    = 4;
   localparam int STEP_W     = 4;   // sixteen two-bit conversion steps

   localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_type;
   typedef logic [DIGIT_W-1:0]                 digit_index_type;

   // one double-dabble step: adjust each digit, then shift one bit in
   function automatic bcd_type dabble_step(input bcd_type bcd, input logic bit_in);
      bcd_type                         adj;
      logic [NUM_DIGITS*DIGIT_W-1:0]   flat;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
      end
      flat = adj;
      return bcd_type'({flat[NUM_DIGITS*DIGIT_W-2:0], bit_in});
   endfunction

endpackage

### rtl/signed_decimal_formatter.sv
// signed 32-bit integer to decimal ascii, one character per beat
// depends on sdf_pkg and assert_macros.svh
`include "assert_macros.svh"

// Usage:
//   Drive req_value and pulse start while busy is low; the value is taken at
//   that clock edge and busy rises in the next cycle.
//   Characters leave on rsp_text_char, one per cycle, with rsp_strobe high
//   for exactly that cycle: a '-' first for negative values, then the
//   digits most significant first, no leading zeros (zero prints as '0').
//   rsp_is_last marks the final character, which also carries the total
//   count in rsp_char_count (1 to 11); earlier characters carry count 0.
//   The magnitude runs through a double-dabble shift register two bits
//   per cycle, then the ST_SIZE state sizes the digit string, and each
//   character is registered into the single output register in ST_EMIT.
//   A new number is accepted only once the last character of the previous
//   one is registered: the conversion shifter and the output register
//   serve one number at a time.
//   The receiver cannot stall: each beat is shown for one cycle only.
//   Synchronous reset returns to idle, drops busy and the strobe, and
//   abandons any number in progress.
module signed_decimal_formatter
   import sdf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_strobe,
   output logic [CHAR_W-1:0]   rsp_text_char,
   output logic                rsp_is_last,
   output logic [COUNT_W-1:0]  rsp_char_count
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SIZE = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'((VALUE_W / 2) - 1);

   logic [1:0]           state_ff, state_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   bcd_type              bcd_ff, bcd_in;
   logic                 neg_ff, neg_in;
   logic                 sign_pend_ff, sign_pend_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   digit_index_type      idx_ff, idx_in;
   logic [COUNT_W-1:0]   ndig_ff, ndig_in;

   logic                 strobe_ff, strobe_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic [COUNT_W-1:0]   ndig_found;

   // significant digit count of the finished bcd word, at least one
   always_comb begin
      ndig_found = COUNT_W'(1);
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i] != '0) begin
            ndig_found = COUNT_W'(i + 1);
         end
      end
   end

   // sequencer: accept, convert, size, emit
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      sign_pend_in = sign_pend_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      ndig_in      = ndig_ff;
      strobe_in    = 1'b0;
      char_in      = char_ff;
      last_in      = last_ff;
      count_in     = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = req_value[VALUE_W-1];
               mag_in   = req_value[VALUE_W-1] ? (~req_value + VALUE_W'(1)) : req_value;
               bcd_in   = '0;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            // two magnitude bits into the bcd word per cycle
            bcd_in  = dabble_step(dabble_step(bcd_ff, mag_ff[VALUE_W-1]),
                                  mag_ff[VALUE_W-2]);
            mag_in  = {mag_ff[VALUE_W-3:0], 2'b00};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            ndig_in      = ndig_found;
            idx_in       = digit_index_type'(ndig_found - COUNT_W'(1));
            sign_pend_in = neg_ff;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            if (sign_pend_ff) begin
               char_in      = MINUS_CHAR;
               last_in      = 1'b0;
               count_in     = '0;
               sign_pend_in = 1'b0;
            end else begin
               char_in = DIGIT_ZERO + CHAR_W'(bcd_ff[idx_ff]);
               if (idx_ff == '0) begin
                  last_in  = 1'b1;
                  count_in = ndig_ff + COUNT_W'(neg_ff);
                  state_in = ST_IDLE;
               end else begin
                  last_in  = 1'b0;
                  count_in = '0;
                  idx_in   = idx_ff - digit_index_type'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      bcd_ff       <= bcd_in;
      neg_ff       <= neg_in;
      sign_pend_ff <= sign_pend_in;
      step_ff      <= step_in;
      idx_ff       <= idx_in;
      ndig_ff      <= ndig_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      count_ff     <= count_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_text_char  = char_ff;
   assign rsp_is_last    = last_ff;
   assign rsp_char_count = count_ff;

   // checks
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLIES(a_beat_from_work, clock, reset, rsp_strobe, $past(busy))
   `ASSERT_IMPLIES(a_last_count, clock, reset, rsp_strobe && rsp_is_last,
                   rsp_char_count != '0)
   `ASSERT_IMPLIES(a_mid_count, clock, reset, rsp_strobe && !rsp_is_last,
                   rsp_char_count == '0)
   `ASSERT_NEXT(a_beats_contiguous, clock, reset, rsp_strobe && !rsp_is_last, rsp_strobe)

endmodule
